// File: sv/mscw_pkg.sv
// shared types and constants for the multi-screen cursor wrap block
`default_nettype none
package mscw_pkg;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_BUILD  = 2'd2,
        CMD_SAMPLE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_NO_SCR = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        SIDE_LEFT   = 2'd0,
        SIDE_RIGHT  = 2'd1,
        SIDE_TOP    = 2'd2,
        SIDE_BOTTOM = 2'd3
    } side_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BLD_RD,
        S_BLD_RDB,
        S_BLD_CMP,
        S_BLD_WA,
        S_BLD_WB,
        S_MRG_RD,
        S_MRG_CMP,
        S_FND_RD,
        S_FND_CMP,
        S_SIDE,
        S_WRP_RD,
        S_WRP_CMP,
        S_OUT
    } state_t;

    typedef struct packed {
        logic signed [15:0] l;
        logic signed [15:0] t;
        logic signed [15:0] r;
        logic signed [15:0] b;
    } rect_t;

    // controller to datapath
    typedef struct packed {
        logic latch_in;    // capture accepted beat
        logic clr_cnt;     // clear both counts
        logic add_scr;     // write screen, bump count
        logic set_full;
        logic set_noscr;
        logic clr_merge;   // merge count to zero
        logic ld_a;        // read screen i
        logic ld_b;        // capture screen i, read screen j
        logic pair_eval;   // evaluate pair i,j
        logic wr_seg_a;
        logic wr_seg_b;
        logic mrg_test;    // compare merge entry
        logic fnd_test;    // compare screen for containment
        logic side_eval;
        logic wrp_test;
        logic out_load;
        logic idx_clr;
        logic idx_inc;
        logic j_init;      // j = i + 1
        logic j_inc;
        logic i_inc;
    } ctrl_t;

    // datapath to controller
    typedef struct packed {
        logic scr_full;
        logic scr_empty;
        logic idx_last_scr;  // entry under compare is the last screen
        logic j_last;        // j >= screen_count-1
        logic i_last;        // i >= screen_count-1
        logic mrg_last;      // entry under compare is the last merge entry
        logic mrg_empty;
        logic pair_ok;
        logic pair_fits;
        logic mrg_hit;       // cursor on the merge entry under compare
        logic scr_hit;       // cursor inside the screen under compare
        logic on_border;
        logic held;
        cmd_t cmd;
    } stat_t;

endpackage
`default_nettype wire

// File: sv/mscw_if.sv
// valid/ready channel interface
`default_nettype none
interface mscw_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/mscw_ram.sv
// generic ram, one write port and one registered read port
`default_nettype none
module mscw_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: sv/mscw_ctrl.sv
// sequencer for clear, add, build and cursor sample commands
`default_nettype none
module mscw_ctrl
    import mscw_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  wire logic out_ready,
    input  wire stat_t st,
    output ctrl_t     ctl
);
    state_t state_reg, state_next;
    logic   ov_reg, ov_next;

    assign out_valid = ov_reg;
    assign in_ready  = (state_reg == S_IDLE) && !ov_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        if (state_reg == S_OUT)
        begin
            ov_next = 1'b1;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = S_IDLE;
                    unique case (st.cmd)
                        CMD_CLEAR, CMD_ADD: state_next = S_OUT;
                        CMD_BUILD:          state_next = S_BLD_RD;
                        CMD_SAMPLE:         state_next = S_MRG_RD;
                        default:            state_next = S_OUT;
                    endcase
                end
            end
            S_BLD_RD:
            begin
                if (st.scr_empty || st.i_last) state_next = S_OUT;
                else                           state_next = S_BLD_RDB;
            end
            S_BLD_RDB: state_next = S_BLD_CMP;
            S_BLD_CMP:
            begin
                if (st.pair_ok && st.pair_fits) state_next = S_BLD_WA;
                else                            state_next = S_BLD_RD;
            end
            S_BLD_WA: state_next = S_BLD_WB;
            S_BLD_WB: state_next = S_BLD_RD;
            S_MRG_RD:
            begin
                if (st.scr_empty || st.held || st.mrg_empty) state_next = st.scr_empty
                    || st.held ? S_OUT : S_FND_RD;
                else state_next = S_MRG_CMP;
            end
            S_MRG_CMP:
            begin
                if (st.mrg_hit)       state_next = S_OUT;
                else if (st.mrg_last) state_next = S_FND_RD;
                else                  state_next = S_MRG_CMP;
            end
            S_FND_RD: state_next = S_FND_CMP;
            S_FND_CMP:
            begin
                if (st.scr_hit || st.idx_last_scr) state_next = S_SIDE;
                else                               state_next = S_FND_CMP;
            end
            S_SIDE:
            begin
                if (st.on_border) state_next = S_WRP_RD;
                else              state_next = S_OUT;
            end
            S_WRP_RD: state_next = S_WRP_CMP;
            S_WRP_CMP:
            begin
                if (st.idx_last_scr) state_next = S_OUT;
            end
            S_OUT:
            begin
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    ctl.latch_in = 1'b1;
                    ctl.idx_clr  = 1'b1;
                    unique case (st.cmd)
                        CMD_CLEAR: ctl.clr_cnt = 1'b1;
                        CMD_ADD:
                        begin
                            if (st.scr_full) ctl.set_full = 1'b1;
                            else             ctl.add_scr  = 1'b1;
                        end
                        CMD_BUILD:  ctl.clr_merge = 1'b1;
                        CMD_SAMPLE: ;
                        default: ;
                    endcase
                end
            end
            S_BLD_RD:
            begin
                if (st.scr_empty) ctl.set_noscr = 1'b1;
                ctl.ld_a = 1'b1;
            end
            S_BLD_RDB: ctl.ld_b = 1'b1;
            S_BLD_CMP:
            begin
                ctl.pair_eval = 1'b1;
                if (!(st.pair_ok && st.pair_fits))
                begin
                    if (st.j_last)
                    begin
                        ctl.i_inc = 1'b1;
                    end
                    else
                    begin
                        ctl.j_inc = 1'b1;
                    end
                end
            end
            S_BLD_WA: ctl.wr_seg_a = 1'b1;
            S_BLD_WB:
            begin
                ctl.wr_seg_b = 1'b1;
                if (st.j_last) ctl.i_inc = 1'b1;
                else           ctl.j_inc = 1'b1;
            end
            S_MRG_RD:
            begin
                if (st.scr_empty) ctl.set_noscr = 1'b1;
                if (!st.mrg_empty && !st.scr_empty && !st.held) ctl.idx_inc = 1'b1;
            end
            S_MRG_CMP:
            begin
                ctl.mrg_test = 1'b1;
                if (st.mrg_last || st.mrg_hit) ctl.idx_clr = 1'b1;
                else                           ctl.idx_inc = 1'b1;
            end
            S_FND_RD: ctl.idx_inc = 1'b1;
            S_FND_CMP:
            begin
                ctl.fnd_test = 1'b1;
                if (st.scr_hit || st.idx_last_scr) ctl.idx_clr = 1'b1;
                else                               ctl.idx_inc = 1'b1;
            end
            S_SIDE: ctl.side_eval = 1'b1;
            S_WRP_RD: ctl.idx_inc = 1'b1;
            S_WRP_CMP:
            begin
                ctl.wrp_test = 1'b1;
                ctl.idx_inc  = 1'b1;
            end
            S_OUT: ctl.out_load = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: sv/mscw_dp.sv
// tables, counters, geometry compares and result register
`default_nettype none
module mscw_dp
    import mscw_pkg::*;
#(
    parameter int MAX_SCREENS = 8,
    parameter int MAX_MERGES  = 56
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_t              ctl,
    output stat_t                   st,
    input  wire logic [1:0]         in_command,
    input  wire logic signed [15:0] in_l,
    input  wire logic signed [15:0] in_t,
    input  wire logic signed [15:0] in_r,
    input  wire logic signed [15:0] in_b,
    input  wire logic signed [15:0] in_x,
    input  wire logic signed [15:0] in_y,
    input  wire logic               in_held,
    output logic signed [15:0]      new_x,
    output logic signed [15:0]      new_y,
    output logic                    moved,
    output logic [1:0]              status
);
    localparam int SW = $clog2(MAX_SCREENS + 1);
    localparam int SA = (MAX_SCREENS > 1) ? $clog2(MAX_SCREENS) : 1;
    localparam int MD = (MAX_MERGES > 1) ? MAX_MERGES : 2;
    localparam int MW = $clog2(MD + 1);
    localparam int MA = $clog2(MD);
    localparam int IW = (SW > MW) ? SW : MW;

    logic [SW-1:0] scnt_reg;
    logic [MW-1:0] mcnt_reg;
    logic [IW-1:0] idx_reg;
    logic [SW-1:0] i_reg, j_reg;
    cmd_t          cmd_reg;
    logic signed [15:0] x_reg, y_reg;
    logic          held_reg;
    rect_t         a_reg, c_reg;
    logic [63:0]   sega_reg, segb_reg;
    logic          hit_reg, found_reg, set_reg, border_reg;
    side_t         side_reg;
    logic signed [16:0] fx_reg, fy_reg;   // wrap target at full precision
    status_t       st_reg;
    logic signed [15:0] ox_reg, oy_reg;
    logic          om_reg;
    logic [1:0]    os_reg;

    // screen ram
    logic          s_we;
    logic [SA-1:0] s_waddr, s_raddr;
    logic [63:0]   s_rdata;
    rect_t         srd;
    assign s_we    = ctl.add_scr;
    assign s_waddr = scnt_reg[SA-1:0];
    assign srd     = rect_t'(s_rdata);

    mscw_ram #(.WIDTH(64), .DEPTH(MAX_SCREENS > 1 ? MAX_SCREENS : 2)) u_scr (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata ({in_l, in_t, in_r, in_b}),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // merge ram, second entry of a pair goes one above the count
    logic          m_we;
    logic [MA-1:0] m_waddr, m_raddr;
    logic [63:0]   m_wdata, m_rdata;
    logic signed [15:0] mx0, my0, mx1, my1;
    assign m_we    = (ctl.wr_seg_a || ctl.wr_seg_b) && (MAX_MERGES > 1);
    assign m_waddr = mcnt_reg[MA-1:0] + MA'(ctl.wr_seg_b);
    assign m_wdata = ctl.wr_seg_a ? sega_reg : segb_reg;
    assign m_raddr = idx_reg[MA-1:0];
    assign {mx0, my0, mx1, my1} = m_rdata;

    mscw_ram #(.WIDTH(64), .DEPTH(MD)) u_mrg (
        .clk   (clk),
        .we    (m_we),
        .waddr (m_waddr),
        .wdata (m_wdata),
        .raddr (m_raddr),
        .rdata (m_rdata)
    );

    // build reads screen i, then captures it while screen j is read
    assign s_raddr = ctl.ld_a ? i_reg[SA-1:0] :
                     (ctl.ld_b ? j_reg[SA-1:0] : idx_reg[SA-1:0]);

    // pair geometry, 17-bit signed for full precision
    logic signed [16:0] ar, al, at, ab, br_, bl, bt, bb;
    logic vert, horz, ar_bl, bb_ok;
    logic signed [16:0] s_v, e_v, s_h, e_h;
    assign al = 17'(a_reg.l); assign ar = 17'(a_reg.r);
    assign at = 17'(a_reg.t); assign ab = 17'(a_reg.b);
    assign bl = 17'(srd.l);   assign br_ = 17'(srd.r);
    assign bt = 17'(srd.t);   assign bb = 17'(srd.b);
    assign vert  = (ar == bl) || (al == br_);
    assign horz  = (ab == bt) || (at == bb);
    assign s_v   = (at > bt) ? at : bt;
    assign e_v   = (ab < bb) ? ab : bb;
    assign s_h   = (al > bl) ? al : bl;
    assign e_h   = (ar < br_) ? ar : br_;
    assign ar_bl = (ar == bl);
    assign bb_ok = vert ? (s_v <= e_v) : (horz && (s_h <= e_h));

    logic [63:0] pa, pb;
    logic signed [15:0] sv16, ev16, sh16, eh16;
    assign sv16 = s_v[15:0];
    assign ev16 = e_v[15:0];
    assign sh16 = s_h[15:0];
    assign eh16 = e_h[15:0];
    always_comb
    begin
        if (vert)
        begin
            if (ar_bl)
            begin
                pa = {a_reg.r - 16'sd1, sv16, a_reg.r - 16'sd1, ev16};
                pb = {srd.l, sv16, srd.l, ev16};
            end
            else
            begin
                pa = {a_reg.l, sv16, a_reg.l, ev16};
                pb = {srd.r - 16'sd1, sv16, srd.r - 16'sd1, ev16};
            end
        end
        else
        begin
            if (ab == bt)
            begin
                pa = {sh16, a_reg.b - 16'sd1, eh16, a_reg.b - 16'sd1};
                pb = {sh16, srd.t, eh16, srd.t};
            end
            else
            begin
                pa = {sh16, a_reg.t, eh16, a_reg.t};
                pb = {sh16, srd.b - 16'sd1, eh16, srd.b - 16'sd1};
            end
        end
    end

    // sample geometry
    logic mhit, contains, rowcov, colcov;
    logic signed [16:0] xs, ys;
    assign xs = 17'(x_reg);
    assign ys = 17'(y_reg);
    assign mhit = (mx0 <= x_reg) && (x_reg <= mx1) && (my0 <= y_reg) && (y_reg <= my1);
    assign contains = (srd.l <= x_reg) && (x_reg < srd.r)
                   && (srd.t <= y_reg) && (y_reg < srd.b);
    assign rowcov = (srd.t <= y_reg) && (y_reg < srd.b);
    assign colcov = (srd.l <= x_reg) && (x_reg < srd.r);

    logic is_l, is_r, is_t, is_b;
    assign is_l = xs <= 17'(c_reg.l);
    assign is_r = xs >= 17'(c_reg.r) - 17'sd1;
    assign is_t = ys <= 17'(c_reg.t);
    assign is_b = ys >= 17'(c_reg.b) - 17'sd1;

    // status to controller; table walks compare entry idx-1 while idx is read
    logic [SW-1:0] slast;
    assign slast = scnt_reg - SW'(1);
    always_comb
    begin
        st.scr_full     = (scnt_reg >= SW'(MAX_SCREENS));
        st.scr_empty    = (scnt_reg == '0);
        st.idx_last_scr = (IW'(scnt_reg) == idx_reg);
        st.j_last       = (j_reg >= slast);
        st.i_last       = (i_reg >= slast) || (scnt_reg == '0);
        st.mrg_last     = (IW'(mcnt_reg) == idx_reg);
        st.mrg_empty    = (mcnt_reg == '0);
        st.pair_ok      = (vert || horz) && bb_ok;
        st.pair_fits    = (32'(mcnt_reg) + 32'd2 <= 32'(MAX_MERGES));
        st.mrg_hit      = mhit;
        st.scr_hit      = contains;
        st.on_border    = is_l || is_r || is_t || is_b;
        st.held         = held_reg;
        st.cmd          = cmd_t'(in_command);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scnt_reg  <= '0;
            mcnt_reg  <= '0;
            idx_reg   <= '0;
            i_reg     <= '0;
            j_reg     <= '0;
            cmd_reg   <= CMD_CLEAR;
            st_reg    <= ST_OK;
        end
        else
        begin
            if (ctl.latch_in)
            begin
                cmd_reg  <= cmd_t'(in_command);
                st_reg   <= ST_OK;
                i_reg    <= '0;
                j_reg    <= SW'(1);
            end
            if (ctl.clr_cnt)
            begin
                scnt_reg <= '0;
                mcnt_reg <= '0;
            end
            if (ctl.add_scr)   scnt_reg <= scnt_reg + SW'(1);
            if (ctl.set_full)  st_reg <= ST_FULL;
            if (ctl.set_noscr) st_reg <= ST_NO_SCR;
            if (ctl.clr_merge) mcnt_reg <= '0;
            if (ctl.wr_seg_b)  mcnt_reg <= mcnt_reg + MW'(2);
            if (ctl.i_inc)
            begin
                i_reg <= i_reg + SW'(1);
                j_reg <= i_reg + SW'(2);
            end
            if (ctl.j_inc) j_reg <= j_reg + SW'(1);
            if (ctl.idx_clr)      idx_reg <= '0;
            else if (ctl.idx_inc) idx_reg <= idx_reg + IW'(1);
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (ctl.latch_in)
        begin
            x_reg     <= in_x;
            y_reg     <= in_y;
            held_reg  <= in_held;
            hit_reg   <= 1'b0;
            found_reg <= 1'b0;
            set_reg   <= 1'b0;
            border_reg <= 1'b0;
        end
        // ram output of screen i arrives in the cycle after ld_a
        if (ctl.ld_b) a_reg <= srd;
        if (ctl.pair_eval)
        begin
            sega_reg <= pa;
            segb_reg <= pb;
        end
        if (ctl.mrg_test && mhit) hit_reg <= 1'b1;
        if (ctl.fnd_test)
        begin
            if (contains) found_reg <= 1'b1;
            if (contains || !found_reg) c_reg <= srd;
        end
        if (ctl.side_eval)
        begin
            border_reg <= is_l || is_r || is_t || is_b;
            if (is_l)
            begin
                side_reg <= SIDE_LEFT;
                fx_reg <= '0; fy_reg <= 17'(y_reg);
            end
            else if (is_r)
            begin
                side_reg <= SIDE_RIGHT;
                fx_reg <= '0; fy_reg <= 17'(y_reg);
            end
            else if (is_t)
            begin
                side_reg <= SIDE_TOP;
                fx_reg <= 17'(x_reg); fy_reg <= '0;
            end
            else
            begin
                side_reg <= SIDE_BOTTOM;
                fx_reg <= 17'(x_reg); fy_reg <= '0;
            end
        end
        if (ctl.wrp_test)
        begin
            unique case (side_reg)
                SIDE_LEFT:
                    if (rowcov && (!set_reg || 17'(srd.r) > fx_reg))
                    begin
                        fx_reg <= 17'(srd.r) - 17'sd2; set_reg <= 1'b1;
                    end
                SIDE_RIGHT:
                    if (rowcov && (!set_reg || 17'(srd.l) < fx_reg))
                    begin
                        fx_reg <= 17'(srd.l) + 17'sd1; set_reg <= 1'b1;
                    end
                SIDE_TOP:
                    if (colcov && (!set_reg || 17'(srd.b) > fy_reg))
                    begin
                        fy_reg <= 17'(srd.b) - 17'sd2; set_reg <= 1'b1;
                    end
                SIDE_BOTTOM:
                    if (colcov && (!set_reg || 17'(srd.t) < fy_reg))
                    begin
                        fy_reg <= 17'(srd.t) + 17'sd1; set_reg <= 1'b1;
                    end
                default: ;
            endcase
        end
        if (ctl.out_load)
        begin
            if (cmd_reg == CMD_SAMPLE)
            begin
                if (st_reg == ST_NO_SCR || held_reg || hit_reg || !border_reg)
                begin
                    ox_reg <= x_reg; oy_reg <= y_reg; om_reg <= 1'b0;
                end
                else
                begin
                    ox_reg <= fx_reg[15:0]; oy_reg <= fy_reg[15:0]; om_reg <= 1'b1;
                end
            end
            else
            begin
                ox_reg <= 16'sd0; oy_reg <= 16'sd0; om_reg <= 1'b0;
            end
            os_reg <= st_reg;
        end
    end

    assign new_x  = ox_reg;
    assign new_y  = oy_reg;
    assign moved  = om_reg;
    assign status = os_reg;
endmodule
`default_nettype wire

// File: sv/multi_screen_cursor_wrap.sv
// top level of the multi-screen cursor wrap block
`default_nettype none
// multi-screen cursor wrap: one command beat in, one result beat out.
// the command field picks clear, add screen, build or cursor sample. clear
// and add go from idle straight to the output state, which loads the
// result and raises the result valid. build walks every screen pair i<j
// through the single screen ram read port: it reads screen i, then screen
// j, compares them, and writes two merge entries when the pair abuts and
// the merge table has room. a cursor sample walks the merge table one entry
// a cycle, then the screen table twice (containment, then wrap target); a
// held button, a merge hit or no border cuts that short.
// one item is in flight at a time; a new beat is taken the cycle after the
// previous result beat has been taken. screen and merge tables power up
// undefined and only entries below their counts are used, so there is no
// clearing pass.
module multi_screen_cursor_wrap
    import mscw_pkg::*;
#(
    parameter int MAX_SCREENS = 8,
    parameter int MAX_MERGES  = 56
) (
    input  wire logic clk,
    input  wire logic rst_n,
    mscw_if.sink      in_ch,
    mscw_if.source    out_ch
);
    // input beat layout: command, rect l/t/r/b, cursor x/y, button
    logic [1:0]         command;
    logic signed [15:0] rect_left, rect_top, rect_right, rect_bottom;
    logic signed [15:0] cursor_x, cursor_y;
    logic               button_held;
    assign {command, rect_left, rect_top, rect_right, rect_bottom,
            cursor_x, cursor_y, button_held} = in_ch.data;

    logic signed [15:0] new_x, new_y;
    logic               moved;
    logic [1:0]         status;
    assign out_ch.data = {new_x, new_y, moved, status};

    ctrl_t ctl;
    stat_t st;

    mscw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .st        (st),
        .ctl       (ctl)
    );

    mscw_dp #(.MAX_SCREENS(MAX_SCREENS), .MAX_MERGES(MAX_MERGES)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .st         (st),
        .in_command (command),
        .in_l       (rect_left),
        .in_t       (rect_top),
        .in_r       (rect_right),
        .in_b       (rect_bottom),
        .in_x       (cursor_x),
        .in_y       (cursor_y),
        .in_held    (button_held),
        .new_x      (new_x),
        .new_y      (new_y),
        .moved      (moved),
        .status     (status)
    );
endmodule
`default_nettype wire
